// File: src/cfce_pkg.sv
`timescale 1ns / 1ps

package cfce_pkg;

    // Flash geometry (powers of two)
    localparam int unsigned FLASH_BYTES  = 2097152;
    localparam int unsigned SECTOR_BYTES = 4096;
    localparam int unsigned PAGE_BYTES   = 256;

    localparam int unsigned FLASH_AW   = $clog2(FLASH_BYTES);
    localparam int unsigned PAGE_AW    = $clog2(PAGE_BYTES);
    localparam int unsigned PAGE_NUM_W = FLASH_AW - PAGE_AW;

    localparam logic [FLASH_AW-1:0] SEC_MASK = FLASH_AW'(SECTOR_BYTES - 1);

    // Command bytes
    localparam logic [7:0] CMD_UNLOCK = 8'h66;
    localparam logic [7:0] CMD_FLASH  = 8'h99;
    localparam logic [7:0] SEQ_END    = 8'hF0;
    localparam logic [7:0] SEQ_PAIR   = 8'h00;
    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_WRDI    = 8'h04;
    localparam logic [7:0] OP_ERASE   = 8'h20;
    localparam logic [7:0] OP_PROG    = 8'h02;
    localparam logic [7:0] OP_READ    = 8'h3B;
    localparam logic [7:0] ERASED     = 8'hFF;

    typedef logic [63:0] t_cmd_word;
    typedef logic [31:0] t_read_data;

    // Decoded command class
    typedef enum logic [3:0] {
        K_REJECT,
        K_NOP,
        K_UNLOCK,
        K_WREN,
        K_WRDI,
        K_ERASE,
        K_PROG_START,
        K_PROG_PAIR,
        K_SEQ_END,
        K_READ
    } t_kind;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_CLEAR,
        MEM_ERASE,
        MEM_WRITE,
        MEM_READ
    } t_mem_op;

    typedef struct packed {
        logic    in_ready;
        logic    cnt_clr;
        logic    cnt_inc;
        t_mem_op mem_op;
        logic    commit;
    } t_dp_cmd;

    typedef struct packed {
        t_kind      kind;
        logic       in_fire;
        logic       out_free;
        logic       cnt_sec_last;
        logic       cnt_all_last;
        logic [1:0] cnt_lo;
    } t_dp_status;

endpackage

// File: src/cfce_in_if.sv
`timescale 1ns / 1ps

interface cfce_in_if;
    logic                 valid;
    logic                 ready;
    cfce_pkg::t_cmd_word  command_word;
    logic                 key2_state;

    modport source (output valid, output command_word, output key2_state, input ready);
    modport sink   (input valid, input command_word, input key2_state, output ready);
endinterface

// File: src/cfce_out_if.sv
`timescale 1ns / 1ps

interface cfce_out_if;
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    cfce_pkg::t_read_data read_data;

    modport source (output valid, output accepted, output read_data, input ready);
    modport sink   (input valid, input accepted, input read_data, output ready);
endinterface

// File: src/cfce_ram.sv
`timescale 1ns / 1ps

module cfce_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/cfce_ctrl.sv
`timescale 1ns / 1ps

module cfce_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cfce_pkg::t_dp_status i_sts,
    output cfce_pkg::t_dp_cmd    o_cmd
);
    import cfce_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ERASE,
        S_WRITE,
        S_READ,
        S_READ_TAIL,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mem_op  = MEM_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.mem_op  = MEM_CLEAR;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_all_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_fire) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.cnt_clr = 1'b1;
                unique case (i_sts.kind)
                    K_ERASE:      n_state = S_ERASE;
                    K_PROG_START: n_state = S_WRITE;
                    K_PROG_PAIR:  n_state = S_WRITE;
                    K_READ:       n_state = S_READ;
                    default:      n_state = S_FINISH;
                endcase
            end
            S_ERASE: begin
                o_cmd.mem_op  = MEM_ERASE;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_sec_last) begin
                    n_state = S_FINISH;
                end
            end
            S_WRITE: begin
                o_cmd.mem_op  = MEM_WRITE;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_lo[0]) begin
                    n_state = S_FINISH;
                end
            end
            S_READ: begin
                o_cmd.mem_op  = MEM_READ;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_lo == 2'd3) begin
                    n_state = S_READ_TAIL;
                end
            end
            S_READ_TAIL: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_fire_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.in_fire |-> r_state == S_IDLE)
        else $error("transaction accepted outside idle");

    a_fire_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.in_fire |=> r_state == S_DECODE)
        else $error("accepted transaction not decoded");

    a_write_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> (i_sts.kind == K_PROG_START || i_sts.kind == K_PROG_PAIR))
        else $error("program write without program command");

    a_read_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_READ_TAIL) |-> i_sts.kind == K_READ)
        else $error("read sequence without read command");

endmodule

// File: src/cfce_dp.sv
`timescale 1ns / 1ps

module cfce_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cfce_in_if.sink              i_cmd,
    cfce_out_if.source           o_rsp,
    input  cfce_pkg::t_dp_cmd    i_ctl,
    output cfce_pkg::t_dp_status o_sts
);
    import cfce_pkg::*;

    // Command capture
    t_cmd_word r_word;
    logic      r_key2;

    // Engine state
    logic                  r_unlocked;
    logic                  r_wen;
    logic                  r_prog;
    logic [PAGE_NUM_W-1:0] r_page;
    logic [PAGE_AW-1:0]    r_offset;

    logic [FLASH_AW-1:0] r_cnt;
    logic                r_rd_vld;
    t_read_data          r_rd_acc;

    logic       r_out_valid;
    logic       r_acc;
    t_read_data r_rdata;

    t_kind               kind;
    logic                in_fire;
    logic [23:0]         addr24;
    logic [FLASH_AW-1:0] addr;
    logic [FLASH_AW-1:0] wbase;
    logic                mem_we;
    logic [FLASH_AW-1:0] mem_addr;
    logic [7:0]          mem_wdata;
    logic [7:0]          mem_rdata;

    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = i_ctl.in_ready;

    assign addr24 = {r_word[31:24], r_word[39:32], r_word[47:40]};
    assign addr   = addr24[FLASH_AW-1:0];

    always_comb begin
        kind = K_REJECT;
        priority if (!(r_key2 || r_unlocked)) begin
            kind = K_REJECT;
        end else if (r_word[7:0] == CMD_UNLOCK) begin
            kind = K_UNLOCK;
        end else if (r_unlocked && r_word[7:0] == CMD_FLASH) begin
            if (r_prog) begin
                priority if (r_word[15:8] == SEQ_END) begin
                    kind = K_SEQ_END;
                end else if (r_word[15:8] == SEQ_PAIR) begin
                    kind = K_PROG_PAIR;
                end else begin
                    kind = K_REJECT;
                end
            end else begin
                priority if (r_word[23:16] == OP_WREN) begin
                    kind = K_WREN;
                end else if (r_word[23:16] == OP_WRDI) begin
                    kind = K_WRDI;
                end else if (r_word[23:16] == OP_ERASE) begin
                    kind = r_wen ? K_ERASE : K_NOP;
                end else if (r_word[23:16] == OP_PROG) begin
                    kind = r_wen ? K_PROG_START : K_NOP;
                end else if (r_word[23:16] == OP_READ) begin
                    kind = K_READ;
                end else begin
                    kind = K_REJECT;
                end
            end
        end else begin
            kind = K_REJECT;
        end
    end

    // Pair writes always start on an even offset, so the odd byte is an OR.
    assign wbase = (kind == K_PROG_START) ? {addr[FLASH_AW-1:PAGE_AW], PAGE_AW'(0)}
                                          : {r_page, r_offset};

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_cnt;
        mem_wdata = ERASED;
        unique case (i_ctl.mem_op)
            MEM_NONE: begin
                mem_addr = r_cnt;
            end
            MEM_CLEAR: begin
                mem_we = 1'b1;
            end
            MEM_ERASE: begin
                mem_we   = 1'b1;
                mem_addr = (addr & ~SEC_MASK) | (r_cnt & SEC_MASK);
            end
            MEM_WRITE: begin
                mem_we   = 1'b1;
                mem_addr = wbase | FLASH_AW'(r_cnt[0]);
                if (kind == K_PROG_START) begin
                    mem_wdata = r_cnt[0] ? r_word[63:56] : r_word[55:48];
                end else begin
                    mem_wdata = r_cnt[0] ? r_word[31:24] : r_word[23:16];
                end
            end
            MEM_READ: begin
                mem_addr = addr + FLASH_AW'(r_cnt[1:0]);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    cfce_ram #(
        .WIDTH(8),
        .DEPTH(FLASH_BYTES)
    ) u_flash (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= i_cmd.command_word;
            r_key2 <= i_cmd.key2_state;
        end
        if (r_rd_vld) begin
            r_rd_acc <= {mem_rdata, r_rd_acc[31:8]};
        end
        if (i_ctl.commit) begin
            r_acc   <= (kind != K_REJECT);
            r_rdata <= (kind == K_READ) ? r_rd_acc : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlocked  <= 1'b0;
            r_wen       <= 1'b0;
            r_prog      <= 1'b0;
            r_page      <= '0;
            r_offset    <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= (i_ctl.mem_op == MEM_READ);
            if (i_ctl.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_ctl.cnt_inc) begin
                r_cnt <= r_cnt + FLASH_AW'(1);
            end
            if (i_ctl.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.commit) begin
                unique case (kind)
                    K_UNLOCK: r_unlocked <= 1'b1;
                    K_WREN:   r_wen <= 1'b1;
                    K_WRDI:   r_wen <= 1'b0;
                    K_ERASE:  r_wen <= 1'b0;
                    K_PROG_START: begin
                        r_wen    <= 1'b0;
                        r_prog   <= 1'b1;
                        r_page   <= addr[FLASH_AW-1:PAGE_AW];
                        r_offset <= PAGE_AW'(2);
                    end
                    K_PROG_PAIR: begin
                        r_offset <= r_offset + PAGE_AW'(2);
                    end
                    K_SEQ_END: begin
                        r_prog   <= 1'b0;
                        r_page   <= '0;
                        r_offset <= '0;
                    end
                    default: begin
                        r_unlocked <= r_unlocked;
                    end
                endcase
            end
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.accepted  = r_acc;
    assign o_rsp.read_data = r_rdata;

    assign o_sts.kind         = kind;
    assign o_sts.in_fire      = in_fire;
    assign o_sts.out_free     = !r_out_valid || o_rsp.ready;
    assign o_sts.cnt_sec_last = (r_cnt & SEC_MASK) == SEC_MASK;
    assign o_sts.cnt_all_last = &r_cnt;
    assign o_sts.cnt_lo       = r_cnt[1:0];

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_acc) |-> r_rdata == '0)
        else $error("rejected transaction carries read data");

    a_offset_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset[0] == 1'b0)
        else $error("program offset left even alignment");

endmodule

// File: src/cart_flash_command_engine.sv
`timescale 1ns / 1ps
// Control commands go from decode straight to the finish step; program writes two bytes,
//   a read fetches four bytes and a sector erase sweeps SECTOR_BYTES bytes.
// Flash access runs one byte per cycle on the single flash memory port; one transaction
//   is in work at a time.
// Reset (synchronous, active low) clears all engine state, then a clearing pass over all
//   FLASH_BYTES bytes fills the flash with 0xFF before any command is taken.

module cart_flash_command_engine (
    input logic        i_clk,
    input logic        i_rst_n,
    cfce_in_if.sink    i_cmd,
    cfce_out_if.source o_rsp
);
    import cfce_pkg::*;

    // Controller sequences the flash port one byte per cycle:
    //   erase sweeps the sector, program writes a byte pair, read fetches four
    //   bytes and a tail step drains the registered RAM output.
    // Engine state and the response are updated together in the finish step,
    //   which waits only while the previous response is still held.
    t_dp_cmd    ctl;
    t_dp_status sts;

    cfce_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_sts  (sts),
        .o_cmd  (ctl)
    );

    // Datapath: command capture, decode, engine registers, flash memory,
    //   read assembly (little-endian) and the response register.
    cfce_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (i_cmd),
        .o_rsp  (o_rsp),
        .i_ctl  (ctl),
        .o_sts  (sts)
    );

endmodule

// File: test/cart_flash_command_engine_test.sv
`timescale 1ns / 1ps

module cart_flash_command_engine_test;
    import cfce_pkg::*;

    // Receiver hold-off used to back the engine up against its input.
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 400;
    // The limit covers the clearing pass after reset. On top of that
    // we allow for every transaction being a sector erase, every receiver
    // stall and sender gap, and the hold-off, with plenty of margin.
    localparam int unsigned CYCLE_LIMIT  = 4 * FLASH_BYTES + 16_000_000;
    localparam int unsigned DIRECTED_ROWS = 24;

    // Bytes that no decoder branch recognizes
    localparam logic [7:0] OP_BOGUS  = 8'h55;
    localparam logic [7:0] SEL_BOGUS = 8'h01;

    typedef struct packed {
        logic       accepted;
        t_read_data read_data;
    } t_rsp;

    // One directed transaction. When hand_set is high the response is typed
    // in here; otherwise it comes from the flash predictor.
    typedef struct packed {
        t_cmd_word word;
        logic      key2;
        logic      hand_set;
        t_rsp      rsp;
    } t_cmd_row;

    localparam t_rsp RSP_REJECT = {1'b0, 32'h0000_0000};
    localparam t_rsp RSP_ACK    = {1'b1, 32'h0000_0000};
    localparam t_rsp RSP_BLANK  = {1'b1, 32'hFFFF_FFFF};

    logic i_clk;
    logic i_rst_n;

    cfce_in_if  cmd_bus ();
    cfce_out_if rsp_bus ();

    cart_flash_command_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    // ------------------------------------------------------------------
    // Flash predictor state. The flash image is sparse: an address that
    // has no entry reads as erased.
    // ------------------------------------------------------------------
    logic                  link_open   = 1'b0;
    logic                  wr_latch    = 1'b0;
    logic                  in_program  = 1'b0;
    logic [PAGE_NUM_W-1:0] prog_page   = '0;
    logic [PAGE_AW-1:0]    prog_offset = '0;
    logic [7:0]            flash_img [int unsigned];

    // Responses still owed by the engine, oldest first
    t_rsp awaited [$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_tick  = 0;
    logic        hold_req    = 1'b0;
    logic        hold_done   = 1'b0;
    t_rsp        want;

    t_cmd_row plan_rows [DIRECTED_ROWS];

    // Clock: 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] flash_byte(input logic [FLASH_AW-1:0] at);
        return flash_img.exists(at) ? flash_img[at] : ERASED;
    endfunction

    // Two bytes at the open page offset; the offset wraps within the page.
    function automatic void store_pair(input logic [7:0] lo, input logic [7:0] hi);
        logic [FLASH_AW-1:0] at;
        at = {prog_page, prog_offset};
        flash_img[at] = lo;
        at = at + 1'b1;
        flash_img[at] = hi;
        prog_offset = prog_offset + PAGE_AW'(2);
    endfunction

    // Applies one card command to the predictor state and returns the
    // response the engine owes for it.
    function automatic t_rsp execute_command(input t_cmd_word w, input logic key2);
        t_rsp                r;
        logic [7:0]          sel;
        logic [7:0]          op;
        logic [FLASH_AW-1:0] addr;
        logic [FLASH_AW-1:0] sect;
        r    = RSP_REJECT;
        sel  = w[15:8];
        op   = w[23:16];
        // byte 3 is the most significant address byte; upper bits drop off
        addr = FLASH_AW'({w[31:24], w[39:32], w[47:40]});
        if (key2 || link_open) begin
            if (w[7:0] == CMD_UNLOCK) begin
                link_open  = 1'b1;
                r.accepted = 1'b1;
            end else if (link_open && w[7:0] == CMD_FLASH) begin
                r.accepted = 1'b1;
                if (in_program) begin
                    if (sel == SEQ_END) begin
                        in_program  = 1'b0;
                        prog_page   = '0;
                        prog_offset = '0;
                    end else if (sel == SEQ_PAIR) begin
                        store_pair(w[23:16], w[31:24]);
                    end else begin
                        r.accepted = 1'b0;
                    end
                end else begin
                    case (op)
                        OP_WREN: wr_latch = 1'b1;
                        OP_WRDI: wr_latch = 1'b0;
                        OP_ERASE: begin
                            if (wr_latch) begin
                                sect = addr & ~SEC_MASK;
                                for (int unsigned i = 0; i < SECTOR_BYTES; i++)
                                    flash_img.delete(sect + i);
                                wr_latch = 1'b0;
                            end
                        end
                        OP_PROG: begin
                            if (wr_latch) begin
                                in_program  = 1'b1;
                                prog_page   = addr[FLASH_AW-1:PAGE_AW];
                                prog_offset = '0;
                                wr_latch    = 1'b0;
                                store_pair(w[55:48], w[63:56]);
                            end
                        end
                        OP_READ: begin
                            for (int k = 0; k < 4; k++)
                                r.read_data[8*k +: 8] = flash_byte(addr + FLASH_AW'(k));
                        end
                        default: r.accepted = 1'b0;
                    endcase
                end
            end
        end
        return r;
    endfunction

    // Flash command word: byte 0 0x99, byte 1 sequence selector, byte 2
    // operation, bytes 3..5 address (MSB first), bytes 6..7 program data.
    function automatic t_cmd_word flash_word(input logic [7:0] sel, input logic [7:0] op,
                                             input logic [23:0] addr,
                                             input logic [7:0] b6, input logic [7:0] b7);
        return {b7, b6, addr[7:0], addr[15:8], addr[23:16], op, sel, CMD_FLASH};
    endfunction

    // Addresses cluster in a few sectors and pages so that reads land on
    // programmed and erased data; the ignored top address bits still toggle.
    function automatic logic [23:0] pick_addr();
        logic [8:0] sector;
        logic [3:0] page;
        case ($urandom_range(0, 3))
            0: sector = 9'h000;
            1: sector = 9'h001;
            2: sector = 9'h1FF;
            default: sector = 9'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: page = 4'h0;
            1: page = 4'h1;
            2: page = 4'hF;
            default: page = 4'($urandom);
        endcase
        return {3'($urandom), sector, page, 8'($urandom)};
    endfunction

    // Offers one transaction and waits for the engine to take it. The sender
    // runs in bursts; a burst boundary inserts a random gap with valid low.
    // The expected response is queued at the accepting edge.
    task automatic offer_command(input t_cmd_word word, input logic key2,
                                 input logic hand_set, input t_rsp hand_rsp);
        int unsigned gap;
        t_rsp        predicted;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap != 0) begin
            cmd_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid        = 1'b1;
        cmd_bus.command_word = word;
        cmd_bus.key2_state   = key2;
        do @(posedge i_clk); while (!cmd_bus.ready);
        predicted = execute_command(word, key2);
        awaited.push_back(hand_set ? hand_rsp : predicted);
        items_sent++;
    endtask

    // Drops valid and waits until every owed response has come back.
    task automatic drain_responses();
        @(negedge i_clk);
        cmd_bus.valid = 1'b0;
        wait (awaited.size() == 0);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned   pick;
        int unsigned   pairs;
        int unsigned   reads;
        logic [23:0]   base_addr;
        bit            held;
        bit            paused;

        held   = 1'b0;
        paused = 1'b0;

        cmd_bus.valid        = 1'b0;
        cmd_bus.command_word = '0;
        cmd_bus.key2_state   = 1'b0;
        i_rst_n              = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // The engine holds ready low through its clearing pass; the first
        // offer simply waits for it.

        plan_rows = '{
            // link still locked: everything rejected, unlock included
            '{64'h0, 1'b0, 1'b1, RSP_REJECT},
            '{{56'hFF_FFFF_FFFF_FFFF, CMD_UNLOCK}, 1'b0, 1'b1, RSP_REJECT},
            // key2 alone does not open flash access
            '{flash_word(SEQ_PAIR, OP_READ, 24'h0, 8'h0, 8'h0), 1'b1, 1'b1, RSP_REJECT},
            '{'1, 1'b1, 1'b1, RSP_REJECT},
            '{{56'h0, CMD_UNLOCK}, 1'b1, 1'b1, RSP_ACK},
            // repeated unlock once open, key2 no longer needed
            '{{56'hFF_FFFF_FFFF_FFFF, CMD_UNLOCK}, 1'b0, 1'b1, RSP_ACK},
            // low byte that is neither unlock nor flash
            '{'1, 1'b0, 1'b1, RSP_REJECT},
            '{64'h0, 1'b0, 1'b1, RSP_REJECT},
            // fresh flash reads as erased, including across the top wrap
            '{flash_word(SEQ_PAIR, OP_READ, 24'h0, 8'h0, 8'h0), 1'b0, 1'b1, RSP_BLANK},
            '{flash_word(8'hFF, OP_READ, 24'hFF_FFFF, 8'hFF, 8'hFF), 1'b0, 1'b1, RSP_BLANK},
            '{flash_word(SEQ_PAIR, OP_BOGUS, 24'h0, 8'h0, 8'h0), 1'b0, 1'b1, RSP_REJECT},
            // erase and program without write enable: accepted, no effect
            '{flash_word(SEQ_PAIR, OP_ERASE, 24'h0, 8'h0, 8'h0), 1'b0, 1'b1, RSP_ACK},
            '{flash_word(SEQ_PAIR, OP_PROG, 24'h0, 8'h12, 8'h34), 1'b0, 1'b1, RSP_ACK},
            '{flash_word(SEQ_PAIR, OP_WREN, 24'h0, 8'h0, 8'h0), 1'b0, 1'b1, RSP_ACK},
            '{flash_word(SEQ_PAIR, OP_WRDI, 24'h0, 8'h0, 8'h0), 1'b0, 1'b1, RSP_ACK},
            '{flash_word(SEQ_PAIR, OP_WREN, 24'h0, 8'h0, 8'h0), 1'b0, 1'b1, RSP_ACK},
            // program start in the last page of flash
            '{flash_word(SEQ_PAIR, OP_PROG, 24'hFF_FFFF, 8'h00, 8'hFF), 1'b0, 1'b1, RSP_ACK},
            '{flash_word(SEQ_PAIR, 8'hA5, 24'h5A_0000, 8'h0, 8'h0), 1'b0, 1'b1, RSP_ACK},
            // unknown selector inside the sequence
            '{flash_word(SEL_BOGUS, OP_READ, 24'h0, 8'h0, 8'h0), 1'b0, 1'b1, RSP_REJECT},
            '{flash_word(SEQ_END, OP_READ, 24'h0, 8'h0, 8'h0), 1'b0, 1'b1, RSP_ACK},
            '{flash_word(SEQ_PAIR, OP_READ, 24'h1F_FF00, 8'h0, 8'h0), 1'b0, 1'b0, RSP_REJECT},
            '{flash_word(SEQ_PAIR, OP_WREN, 24'h0, 8'h0, 8'h0), 1'b0, 1'b1, RSP_ACK},
            '{flash_word(SEQ_PAIR, OP_ERASE, 24'hFF_F123, 8'h0, 8'h0), 1'b0, 1'b1, RSP_ACK},
            '{flash_word(SEQ_PAIR, OP_READ, 24'h1F_FF00, 8'h0, 8'h0), 1'b0, 1'b1, RSP_BLANK}
        };

        foreach (plan_rows[r])
            offer_command(plan_rows[r].word, plan_rows[r].key2,
                          plan_rows[r].hand_set, plan_rows[r].rsp);

        // Random part: mostly well-formed program sequences, reads and
        // erases with random filler bytes, plus noise.
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // program sequence, usually short; now and then long enough
                // to wrap the page offset
                if ($urandom_range(0, 9) != 0)
                    offer_command(flash_word(8'($urandom), OP_WREN, 24'($urandom),
                                             8'($urandom), 8'($urandom)),
                                  1'($urandom), 1'b0, RSP_REJECT);
                base_addr = pick_addr();
                offer_command(flash_word(8'($urandom), OP_PROG, base_addr,
                                         8'($urandom), 8'($urandom)),
                              1'($urandom), 1'b0, RSP_REJECT);
                pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 140)
                                                    : $urandom_range(0, 8);
                repeat (pairs) begin
                    if ($urandom_range(0, 11) == 0)
                        offer_command({32'($urandom), 16'($urandom), SEL_BOGUS, CMD_FLASH},
                                      1'($urandom), 1'b0, RSP_REJECT);
                    else
                        offer_command({32'($urandom), 16'($urandom), SEQ_PAIR, CMD_FLASH},
                                      1'($urandom), 1'b0, RSP_REJECT);
                end
                offer_command({48'({$urandom, $urandom}), SEQ_END, CMD_FLASH},
                              1'($urandom), 1'b0, RSP_REJECT);
                reads = $urandom_range(1, 3);
                repeat (reads)
                    offer_command(flash_word(8'($urandom), OP_READ,
                                             {base_addr[23:8], 8'($urandom)},
                                             8'($urandom), 8'($urandom)),
                                  1'($urandom), 1'b0, RSP_REJECT);
            end else if (pick < 70) begin
                offer_command(flash_word(8'($urandom), OP_READ, pick_addr(),
                                         8'($urandom), 8'($urandom)),
                              1'($urandom), 1'b0, RSP_REJECT);
            end else if (pick < 76) begin
                // erases are slow; keep them rare
                if ($urandom_range(0, 9) < 7)
                    offer_command(flash_word(8'($urandom), OP_WREN, 24'($urandom),
                                             8'($urandom), 8'($urandom)),
                                  1'($urandom), 1'b0, RSP_REJECT);
                offer_command(flash_word(8'($urandom), OP_ERASE, pick_addr(),
                                         8'($urandom), 8'($urandom)),
                              1'($urandom), 1'b0, RSP_REJECT);
            end else begin
                case ($urandom_range(0, 4))
                    0: offer_command({$urandom, $urandom}, 1'($urandom), 1'b0, RSP_REJECT);
                    1: offer_command({32'($urandom), 24'($urandom), CMD_UNLOCK},
                                     1'($urandom), 1'b0, RSP_REJECT);
                    2: offer_command(flash_word(8'($urandom), 8'($urandom), 24'($urandom),
                                                8'($urandom), 8'($urandom)),
                                     1'($urandom), 1'b0, RSP_REJECT);
                    3: offer_command(flash_word(8'($urandom), OP_WRDI, 24'($urandom),
                                                8'($urandom), 8'($urandom)),
                                     1'($urandom), 1'b0, RSP_REJECT);
                    default: offer_command(flash_word(8'($urandom), OP_PROG, pick_addr(),
                                                      8'($urandom), 8'($urandom)),
                                           1'($urandom), 1'b0, RSP_REJECT);
                endcase
            end

            // Back-pressure: one long receiver hold-off while we keep
            // offering, and one full drain with the sender idle.
            if (!held && items_sent >= DIRECTED_ROWS + 120) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && items_sent >= DIRECTED_ROWS + 260) begin
                paused = 1'b1;
                drain_responses();
            end
        end

        drain_responses();
        // allow for a late stray response
        repeat (SECTOR_BYTES + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a pattern picked by tick-counter bits 9:8,
    // with one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                rsp_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                stall_tick++;
                case (stall_tick[9:8])
                    2'd0: rsp_bus.ready = 1'b1;
                    2'd1: rsp_bus.ready = 1'($urandom);
                    2'd2: rsp_bus.ready = (stall_tick % 5) != 0;
                    default: rsp_bus.ready = $urandom_range(0, 3) != 0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Response checker: each transaction out is matched to the oldest
    // owed response.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (awaited.size() == 0) begin
                $error("response with nothing outstanding: accepted %0d read_data %h",
                       rsp_bus.accepted, rsp_bus.read_data);
                fail_count++;
            end else begin
                want = awaited.pop_front();
                if (rsp_bus.accepted !== want.accepted) begin
                    $error("accepted mismatch: expected %0d, actual %0d",
                           want.accepted, rsp_bus.accepted);
                    fail_count++;
                end
                if (rsp_bus.read_data !== want.read_data) begin
                    $error("read_data mismatch: expected %h, actual %h",
                           want.read_data, rsp_bus.read_data);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// File: files.f
src/cfce_pkg.sv
src/cfce_in_if.sv
src/cfce_out_if.sv
src/cfce_ram.sv
src/cfce_ctrl.sv
src/cfce_dp.sv
src/cart_flash_command_engine.sv
test/cart_flash_command_engine_test.sv
